// File: rtl/wed_pkg.sv
package wed_pkg;

   localparam int MAX_LEN = 64;
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int DIST_W = 20;
   localparam int SYM_W = 8;
   localparam int MODE_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIST_W-1:0] COST_CAP = 20'd1000000;
   localparam logic [SYM_W-1:0] GAP_SYMBOL = 8'd45;

   localparam logic [MODE_W-1:0] MODE_UNIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HAMMING = 2'd1;

   localparam logic [CSR_ADDR_W-1:0] REG_COST_MODE = 3'd0;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_SECOND,
      KIND_END
   } kind_type;

   typedef enum logic [1:0] {
      TOK_LOAD,
      TOK_COL,
      TOK_END
   } tok_op_type;

   // one request in flight along the cell row
   typedef struct packed {
      logic              valid;
      tok_op_type        op;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  len;
      logic [MODE_W-1:0] mode;
      logic              first;
      logic [DIST_W-1:0] up;
      logic [DIST_W-1:0] diag;
      logic [DIST_W-1:0] res;
      logic              ovf;
   } token_type;

   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, COST_CAP}) ? COST_CAP : s[DIST_W-1:0];
   endfunction

   function automatic logic [DIST_W-1:0] gap_cost(input logic [MODE_W-1:0] mode);
      return (mode == MODE_HAMMING) ? COST_CAP : DIST_W'(1);
   endfunction

   function automatic logic [DIST_W-1:0] pair_cost(input logic [SYM_W-1:0] a,
                                                   input logic [SYM_W-1:0] b,
                                                   input logic [MODE_W-1:0] mode);
      logic [DIST_W-1:0] c;
      c = '0;
      if (a == GAP_SYMBOL || b == GAP_SYMBOL) begin
         c = gap_cost(mode);
      end else if (a != b) begin
         case (mode)
            MODE_UNIT:    c = DIST_W'(1);
            MODE_HAMMING: c = DIST_W'(2);
            default:      c = DIST_W'(3);
         endcase
      end
      return c;
   endfunction

   // first-column value of row idx: idx gaps, saturated
   function automatic logic [DIST_W-1:0] init_value(input logic [LEN_W-1:0] idx,
                                                    input logic [MODE_W-1:0] mode);
      logic [DIST_W-1:0] v;
      v = DIST_W'(idx);
      if (idx == '0) begin
         v = '0;
      end else if (mode == MODE_HAMMING || v > COST_CAP) begin
         v = COST_CAP;
      end
      return v;
   endfunction

endpackage

// File: rtl/wed_head.sv
module wed_head (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        accept,
   input  logic [1:0]                  req_kind,
   input  logic [wed_pkg::SYM_W-1:0]   req_symbol,
   input  logic [wed_pkg::MODE_W-1:0]  mode,
   output wed_pkg::token_type          tok
);

   logic [wed_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       started_ff, started_in;
   logic                       ovf_ff, ovf_in;
   logic [wed_pkg::DIST_W-1:0] dp0_ff, dp0_in;
   wed_pkg::token_type         tok_ff, tok_in;
   logic [wed_pkg::DIST_W-1:0] diag0;

   always_comb begin
      len_in     = len_ff;
      started_in = started_ff;
      ovf_in     = ovf_ff;
      dp0_in     = dp0_ff;
      diag0      = started_ff ? dp0_ff : '0;

      tok_in        = '0;
      tok_in.op     = wed_pkg::TOK_COL;
      tok_in.symbol = req_symbol;
      tok_in.len    = len_ff;
      tok_in.mode   = mode;
      tok_in.first  = !started_ff;
      tok_in.ovf    = ovf_ff;

      if (accept) begin
         unique case (wed_pkg::kind_type'(req_kind))
            wed_pkg::KIND_FIRST: begin
               // drop characters once the second sequence has begun
               if (!started_ff) begin
                  if (len_ff < wed_pkg::LEN_W'(wed_pkg::MAX_LEN)) begin
                     tok_in.valid = 1'b1;
                     tok_in.op    = wed_pkg::TOK_LOAD;
                     len_in       = len_ff + wed_pkg::LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            wed_pkg::KIND_SECOND: begin
               tok_in.valid = 1'b1;
               tok_in.op    = wed_pkg::TOK_COL;
               tok_in.diag  = diag0;
               tok_in.up    = wed_pkg::sat_add(diag0, wed_pkg::gap_cost(mode));
               dp0_in       = tok_in.up;
               started_in   = 1'b1;
            end
            wed_pkg::KIND_END: begin
               tok_in.valid = 1'b1;
               tok_in.op    = wed_pkg::TOK_END;
               tok_in.res   = diag0;
               len_in       = '0;
               started_in   = 1'b0;
               ovf_in       = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         len_ff     <= len_in;
         started_ff <= started_in;
         ovf_ff     <= ovf_in;
         if (en) begin
            tok_ff <= tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      dp0_ff <= dp0_in;
   end

   assign tok = tok_ff;

endmodule

// File: rtl/wed_cell.sv
module wed_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [wed_pkg::LEN_W-1:0] idx,
   input  wed_pkg::token_type        tok_i,
   output wed_pkg::token_type        tok_o
);

   logic [wed_pkg::SYM_W-1:0]  ch_ff, ch_in;
   logic [wed_pkg::DIST_W-1:0] dp_ff, dp_in;
   wed_pkg::token_type         tok_ff, tok_in;
   logic [wed_pkg::DIST_W-1:0] old, gap, cost_a, cost_b, cost_c, best;
   logic                       active;

   always_comb begin
      gap    = wed_pkg::gap_cost(tok_i.mode);
      old    = tok_i.first ? wed_pkg::init_value(idx, tok_i.mode) : dp_ff;
      cost_a = wed_pkg::sat_add(old, gap);
      cost_b = wed_pkg::sat_add(tok_i.up, gap);
      cost_c = wed_pkg::sat_add(tok_i.diag,
                                wed_pkg::pair_cost(ch_ff, tok_i.symbol, tok_i.mode));
      best   = (cost_a <= cost_b) ? cost_a : cost_b;
      if (cost_c < best) begin
         best = cost_c;
      end

      active = en && tok_i.valid;
      ch_in  = ch_ff;
      dp_in  = dp_ff;
      tok_in = tok_i;

      case (tok_i.op)
         wed_pkg::TOK_LOAD: begin
            if (active && tok_i.len == idx - wed_pkg::LEN_W'(1)) begin
               ch_in = tok_i.symbol;
            end
         end
         wed_pkg::TOK_COL: begin
            // rows past the stored length are left alone
            if (idx <= tok_i.len) begin
               tok_in.up   = best;
               tok_in.diag = old;
               if (active) begin
                  dp_in = best;
               end
            end
         end
         wed_pkg::TOK_END: begin
            if (idx == tok_i.len) begin
               tok_in.res = old;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (en) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      dp_ff <= dp_in;
   end

   assign tok_o = tok_ff;

endmodule

// File: rtl/weighted_edit_distance_core.sv
// A request is registered in the head, then walks the row of cells one cell per cycle, and
// an end-of-pair request has its response registered after the last cell.
// Throughput: one request per cycle of any kind; set by the row of cells, each column
// wavefront moving one cell per cycle. The whole row holds while a response waits.
// Reset: synchronous, active high; clears control state, cost_mode and lengths at once,
// with no clearing pass. Character and column stores are undefined until written.
module weighted_edit_distance_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [wed_pkg::SYM_W-1:0]           req_symbol,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wed_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                rsp_overflow,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wed_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wed_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wed_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [wed_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [wed_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic                       ovf_ff, ovf_in;
   logic                       advance, accept, last_end, csr_write, reg_sel;
   wed_pkg::token_type         chain [wed_pkg::MAX_LEN+1];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   assign reg_sel    = (csr_paddr[2] == wed_pkg::REG_COST_MODE[2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign csr_prdata = reg_sel ? wed_pkg::CSR_DATA_W'(mode_ff) : '0;

   wed_head u_head (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .accept     (accept),
      .req_kind   (req_kind),
      .req_symbol (req_symbol),
      .mode       (mode_ff),
      .tok        (chain[0])
   );

   for (genvar k = 0; k < wed_pkg::MAX_LEN; k++) begin : g_cell
      wed_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (advance),
         .idx   (wed_pkg::LEN_W'(k + 1)),
         .tok_i (chain[k]),
         .tok_o (chain[k+1])
      );
   end

   assign last_end = chain[wed_pkg::MAX_LEN].valid &&
                     chain[wed_pkg::MAX_LEN].op == wed_pkg::TOK_END;

   always_comb begin
      mode_in      = csr_write ? csr_pwdata[wed_pkg::MODE_W-1:0] : mode_ff;
      rsp_valid_in = rsp_valid_ff;
      dist_in      = dist_ff;
      ovf_in       = ovf_ff;
      if (advance) begin
         rsp_valid_in = last_end;
         dist_in      = chain[wed_pkg::MAX_LEN].res;
         ovf_in       = chain[wed_pkg::MAX_LEN].ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= wed_pkg::MODE_UNIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_overflow = ovf_ff;

`ifndef SYNTH
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance <= wed_pkg::COST_CAP)
      else $error("distance above saturation cap");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> mode_ff == $past(csr_pwdata[wed_pkg::MODE_W-1:0]))
      else $error("cost mode not taken from write");

   a_row_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[0]) && $stable(chain[wed_pkg::MAX_LEN]))
      else $error("cell row moved while response held");
`endif

endmodule
